>>> sv/nec_ir_frame_transmitter_core_assert.svh
// ---------------------------------------------------------------------------
// NEC IR transmitter assertion macros
// Concurrent assertion wrappers, compiled out when NO_ASSERTIONS is set.
// ---------------------------------------------------------------------------
`ifndef NEC_IR_FRAME_TRANSMITTER_CORE_ASSERT_SVH
`define NEC_IR_FRAME_TRANSMITTER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define NECTX_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");
`define NECTX_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define NECTX_ASSERT_IMP(label, ante, cons)
`define NECTX_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> sv/nectx_pkg.sv
// ---------------------------------------------------------------------------
// NEC IR transmitter package
// Shared types, command kinds, symbol codes and register indexes.
// ---------------------------------------------------------------------------
package nectx_pkg;

   localparam logic [1:0] KIND_TICK   = 2'd0;
   localparam logic [1:0] KIND_FRAME  = 2'd1;
   localparam logic [1:0] KIND_REPEAT = 2'd2;
   localparam logic [1:0] KIND_NOP    = 2'd3;

   localparam logic [2:0] SYM_NONE   = 3'd0;
   localparam logic [2:0] SYM_WAIT   = 3'd1;
   localparam logic [2:0] SYM_HEADER = 3'd2;
   localparam logic [2:0] SYM_ONE    = 3'd3;
   localparam logic [2:0] SYM_ZERO   = 3'd4;
   localparam logic [2:0] SYM_TAIL   = 3'd5;
   localparam logic [2:0] SYM_REPEAT = 3'd6;

   localparam logic [5:0] FRAME_LAST  = 6'd33;
   localparam logic [5:0] REPEAT_LAST = 6'd1;

   localparam logic [15:0] ADDR_HI_MASK = 16'hFF00;

   localparam logic [2:0] REG_HEADER_MARK   = 3'd0;
   localparam logic [2:0] REG_HEADER_PERIOD = 3'd1;
   localparam logic [2:0] REG_REPEAT_MARK   = 3'd2;
   localparam logic [2:0] REG_REPEAT_PERIOD = 3'd3;
   localparam logic [2:0] REG_BIT_MARK      = 3'd4;
   localparam logic [2:0] REG_ONE_PERIOD    = 3'd5;
   localparam logic [2:0] REG_ZERO_PERIOD   = 3'd6;
   localparam logic [2:0] REG_FRAME         = 3'd7;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] word;
   } cmd_type;

   typedef struct packed {
      logic [7:0] header_mark_ticks;
      logic [7:0] header_period_ticks;
      logic [7:0] repeat_mark_ticks;
      logic [7:0] repeat_period_ticks;
      logic [7:0] bit_mark_ticks;
      logic [7:0] one_period_ticks;
      logic [7:0] zero_period_ticks;
      logic [9:0] frame_ticks;
   } cfg_type;

endpackage

>>> sv/nec_ir_frame_transmitter_core.sv
// ---------------------------------------------------------------------------
// NEC IR frame transmitter core
// Queues NEC frames and repeats as symbols and times them out on tick items.
// ---------------------------------------------------------------------------
// Input stream req_*: tuser carries the request kind (tick, frame, repeat),
// tdata the address and command. Every accepted transaction yields exactly one
// rsp_* transaction carrying carrier_on and busy_res after that item's update.
// A frame request writes 34 symbols (header, 32 bits, tail) to the ring and
// a repeat writes two (repeat, tail); both stop early if the ring fills. A
// tick steps the timers; at the end of a frame the ring is scanned for the
// next header or repeat, one symbol at a time over the single read port.
// The front end and a two-entry command queue keep taking requests while the
// engine works or the result waits, so the receiver may stall freely; once
// all buffers are full req_tready drops until the engine takes a command.
// csr_we writes csr_wdata to register csr_index; idle only, user-enforced.
// Synchronous reset restores the register defaults, empties the ring
// pointers and timers, and drops busy and carrier; ring contents are left.
// ---------------------------------------------------------------------------
module nec_ir_frame_transmitter_core #(
   parameter int RING_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,    // [1:0] req_type
   input  logic [23:0] req_tdata,    // [15:0] address, [23:16] command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,    // [0] carrier_on, [1] busy_res, rest zero
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [9:0]  csr_wdata
);

   nectx_pkg::cfg_type cfg_ff, cfg_in;
   nectx_pkg::cmd_type front_cmd, q_cmd;
   logic               front_valid, front_ready;
   logic               q_valid, q_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            nectx_pkg::REG_HEADER_MARK:   cfg_in.header_mark_ticks   = csr_wdata[7:0];
            nectx_pkg::REG_HEADER_PERIOD: cfg_in.header_period_ticks = csr_wdata[7:0];
            nectx_pkg::REG_REPEAT_MARK:   cfg_in.repeat_mark_ticks   = csr_wdata[7:0];
            nectx_pkg::REG_REPEAT_PERIOD: cfg_in.repeat_period_ticks = csr_wdata[7:0];
            nectx_pkg::REG_BIT_MARK:      cfg_in.bit_mark_ticks      = csr_wdata[7:0];
            nectx_pkg::REG_ONE_PERIOD:    cfg_in.one_period_ticks    = csr_wdata[7:0];
            nectx_pkg::REG_ZERO_PERIOD:   cfg_in.zero_period_ticks   = csr_wdata[7:0];
            nectx_pkg::REG_FRAME:         cfg_in.frame_ticks         = csr_wdata;
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_mark_ticks   <= 8'd16;
         cfg_ff.header_period_ticks <= 8'd24;
         cfg_ff.repeat_mark_ticks   <= 8'd16;
         cfg_ff.repeat_period_ticks <= 8'd20;
         cfg_ff.bit_mark_ticks      <= 8'd1;
         cfg_ff.one_period_ticks    <= 8'd4;
         cfg_ff.zero_period_ticks   <= 8'd2;
         cfg_ff.frame_ticks         <= 10'd192;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   nectx_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .cmd_valid  (front_valid),
      .cmd_ready  (front_ready),
      .cmd        (front_cmd)
   );

   nectx_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_cmd   (front_cmd),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_cmd    (q_cmd)
   );

   nectx_engine #(
      .RING_DEPTH (RING_DEPTH)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_cmd      (q_cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

>>> sv/nectx_front.sv
// ---------------------------------------------------------------------------
// NEC IR transmitter front end
// Accepts requests, builds the 32-bit frame word and registers the command.
// ---------------------------------------------------------------------------
module nectx_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [1:0]          req_tuser,   // [1:0] req_type
   input  logic [23:0]         req_tdata,   // [15:0] address, [23:16] command
   output logic                cmd_valid,
   input  logic                cmd_ready,
   output nectx_pkg::cmd_type  cmd
);

   logic               stage_valid_ff, stage_valid_in;
   nectx_pkg::cmd_type stage_cmd_ff, stage_cmd_in;
   logic [15:0]        address;
   logic [7:0]         command;
   logic [15:0]        addr_word;
   logic               accept;

   assign address    = req_tdata[15:0];
   assign command    = req_tdata[23:16];
   assign req_tready = !stage_valid_ff || cmd_ready;
   assign accept     = req_tvalid && req_tready;
   assign cmd_valid  = stage_valid_ff;
   assign cmd        = stage_cmd_ff;

   // 8-bit address mode sends the low byte and its inverse
   assign addr_word = ((address & nectx_pkg::ADDR_HI_MASK) == 16'd0) ?
                      {~address[7:0], address[7:0]} : address;

   always_comb begin
      stage_cmd_in   = stage_cmd_ff;
      stage_valid_in = stage_valid_ff && !cmd_ready;
      if (accept) begin
         stage_valid_in     = 1'b1;
         stage_cmd_in.word  = {~command, command, addr_word};
         unique case (req_tuser)
            nectx_pkg::KIND_TICK:   stage_cmd_in.kind = nectx_pkg::KIND_TICK;
            nectx_pkg::KIND_FRAME:  stage_cmd_in.kind = nectx_pkg::KIND_FRAME;
            nectx_pkg::KIND_REPEAT: stage_cmd_in.kind = nectx_pkg::KIND_REPEAT;
            default:                stage_cmd_in.kind = nectx_pkg::KIND_NOP;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_cmd_ff <= stage_cmd_in;
   end

endmodule

>>> sv/nectx_fifo.sv
// ---------------------------------------------------------------------------
// NEC IR transmitter command queue
// Two-entry queue between the front end and the symbol engine.
// ---------------------------------------------------------------------------
module nectx_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  nectx_pkg::cmd_type  push_cmd,
   output logic                pop_valid,
   input  logic                pop_ready,
   output nectx_pkg::cmd_type  pop_cmd
);

   nectx_pkg::cmd_type entry_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;
   logic               push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_cmd    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

>>> sv/nectx_engine.sv
// ---------------------------------------------------------------------------
// NEC IR transmitter symbol engine
// Symbol ring, enqueue sequencer, tick timers, frame scan and result register.
// ---------------------------------------------------------------------------
`include "nec_ir_frame_transmitter_core_assert.svh"

module nectx_engine #(
   parameter int RING_DEPTH = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  nectx_pkg::cfg_type  cfg,
   input  logic                q_valid,
   output logic                q_ready,
   input  nectx_pkg::cmd_type  q_cmd,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata   // [0] carrier_on, [1] busy_res
);

   localparam int PTR_W = $clog2(RING_DEPTH);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_ENQ      = 3'd1;
   localparam logic [2:0] ST_TICK     = 3'd2;
   localparam logic [2:0] ST_LOAD_RD  = 3'd3;
   localparam logic [2:0] ST_LOAD     = 3'd4;
   localparam logic [2:0] ST_SCAN_RD  = 3'd5;
   localparam logic [2:0] ST_SCAN_CHK = 3'd6;
   localparam logic [2:0] ST_DONE     = 3'd7;

   function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   logic [2:0]         ring_mem [RING_DEPTH];
   logic [2:0]         rd_data_ff;

   logic [2:0]         state_ff, state_in;
   nectx_pkg::cmd_type cmd_ff, cmd_in;
   logic [5:0]         enq_cnt_ff, enq_cnt_in;
   logic [PTR_W-1:0]   write_pos_ff, write_pos_in;
   logic [PTR_W-1:0]   read_pos_ff, read_pos_in;
   logic [PTR_W-1:0]   ptr_ff, ptr_in;
   logic [9:0]         frame_left_ff, frame_left_in;
   logic [9:0]         period_left_ff, period_left_in;
   logic [7:0]         mark_left_ff, mark_left_in;
   logic               active_ff, active_in;
   logic               carrier_ff, carrier_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_carrier_ff, rsp_carrier_in;
   logic               rsp_busy_ff, rsp_busy_in;

   logic               mem_we;
   logic [2:0]         wr_sym;
   logic [5:0]         enq_last;
   logic [4:0]         bit_idx;
   logic [PTR_W-1:0]   wr_next;
   logic [PTR_W-1:0]   ptr_next;
   logic [7:0]         load_mark;
   logic [9:0]         load_period;
   logic               out_free;

   assign q_ready    = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_busy_ff, rsp_carrier_ff};
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign wr_next    = ring_next(write_pos_ff);
   assign ptr_next   = ring_next(ptr_ff);
   assign enq_last   = (cmd_ff.kind == nectx_pkg::KIND_FRAME) ?
                       nectx_pkg::FRAME_LAST : nectx_pkg::REPEAT_LAST;
   assign bit_idx    = 5'(enq_cnt_ff - 6'd1);

   always_comb begin
      if (cmd_ff.kind == nectx_pkg::KIND_FRAME) begin
         if (enq_cnt_ff == 6'd0) begin
            wr_sym = nectx_pkg::SYM_HEADER;
         end else if (enq_cnt_ff == nectx_pkg::FRAME_LAST) begin
            wr_sym = nectx_pkg::SYM_TAIL;
         end else begin
            wr_sym = cmd_ff.word[bit_idx] ? nectx_pkg::SYM_ONE : nectx_pkg::SYM_ZERO;
         end
      end else begin
         wr_sym = (enq_cnt_ff == 6'd0) ? nectx_pkg::SYM_REPEAT : nectx_pkg::SYM_TAIL;
      end
   end

   always_comb begin
      unique case (rd_data_ff)
         nectx_pkg::SYM_HEADER: begin
            load_mark   = cfg.header_mark_ticks;
            load_period = {2'd0, cfg.header_period_ticks};
         end
         nectx_pkg::SYM_ONE: begin
            load_mark   = cfg.bit_mark_ticks;
            load_period = {2'd0, cfg.one_period_ticks};
         end
         nectx_pkg::SYM_ZERO: begin
            load_mark   = cfg.bit_mark_ticks;
            load_period = {2'd0, cfg.zero_period_ticks};
         end
         nectx_pkg::SYM_TAIL: begin
            load_mark   = cfg.bit_mark_ticks;
            load_period = frame_left_ff;
         end
         nectx_pkg::SYM_REPEAT: begin
            load_mark   = cfg.repeat_mark_ticks;
            load_period = {2'd0, cfg.repeat_period_ticks};
         end
         default: begin
            load_mark   = 8'd0;
            load_period = frame_left_ff;
         end
      endcase
   end

   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      enq_cnt_in     = enq_cnt_ff;
      write_pos_in   = write_pos_ff;
      read_pos_in    = read_pos_ff;
      ptr_in         = ptr_ff;
      frame_left_in  = frame_left_ff;
      period_left_in = period_left_ff;
      mark_left_in   = mark_left_ff;
      active_in      = active_ff;
      carrier_in     = carrier_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_carrier_in = rsp_carrier_ff;
      rsp_busy_in    = rsp_busy_ff;
      mem_we         = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               cmd_in     = q_cmd;
               enq_cnt_in = 6'd0;
               if (q_cmd.kind == nectx_pkg::KIND_FRAME ||
                   q_cmd.kind == nectx_pkg::KIND_REPEAT) begin
                  state_in = ST_ENQ;
               end else if (q_cmd.kind == nectx_pkg::KIND_TICK) begin
                  state_in = ST_TICK;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_ENQ: begin
            mem_we       = 1'b1;
            write_pos_in = wr_next;
            if (wr_next == read_pos_ff || enq_cnt_ff == enq_last) begin
               active_in = 1'b1;
               state_in  = ST_DONE;
            end else begin
               enq_cnt_in = enq_cnt_ff + 6'd1;
            end
         end
         ST_TICK: begin
            state_in = ST_DONE;
            if (!active_ff) begin
               state_in = ST_DONE;
            end else if (frame_left_ff != 10'd0) begin
               frame_left_in = frame_left_ff - 10'd1;
               if (period_left_ff != 10'd0) begin
                  if (mark_left_ff != 8'd0) begin
                     mark_left_in = mark_left_ff - 8'd1;
                     if (mark_left_ff == 8'd1) begin
                        carrier_in = 1'b0;
                     end
                  end
                  period_left_in = period_left_ff - 10'd1;
                  if (period_left_ff == 10'd1 && frame_left_ff != 10'd1) begin
                     ptr_in   = read_pos_ff;
                     state_in = ST_LOAD_RD;
                  end
               end
            end else begin
               // frame over: look for the next header or repeat
               carrier_in = 1'b0;
               ptr_in     = read_pos_ff;
               if (read_pos_ff == write_pos_ff) begin
                  active_in = 1'b0;
               end else begin
                  state_in = ST_SCAN_RD;
               end
            end
         end
         ST_LOAD_RD: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            mark_left_in   = load_mark;
            period_left_in = load_period;
            carrier_in     = (load_mark != 8'd0);
            read_pos_in    = ptr_next;
            state_in       = ST_DONE;
         end
         ST_SCAN_RD: begin
            state_in = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            if (rd_data_ff == nectx_pkg::SYM_HEADER || rd_data_ff == nectx_pkg::SYM_REPEAT) begin
               frame_left_in = cfg.frame_ticks;
               state_in      = ST_LOAD;
            end else if (ptr_next == write_pos_ff) begin
               active_in = 1'b0;
               state_in  = ST_DONE;
            end else begin
               ptr_in   = ptr_next;
               state_in = ST_SCAN_RD;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_carrier_in = carrier_ff;
               rsp_busy_in    = active_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         write_pos_ff   <= '0;
         read_pos_ff    <= '0;
         frame_left_ff  <= 10'd0;
         period_left_ff <= 10'd0;
         mark_left_ff   <= 8'd0;
         active_ff      <= 1'b0;
         carrier_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         write_pos_ff   <= write_pos_in;
         read_pos_ff    <= read_pos_in;
         frame_left_ff  <= frame_left_in;
         period_left_ff <= period_left_in;
         mark_left_ff   <= mark_left_in;
         active_ff      <= active_in;
         carrier_ff     <= carrier_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      enq_cnt_ff     <= enq_cnt_in;
      ptr_ff         <= ptr_in;
      rsp_carrier_ff <= rsp_carrier_in;
      rsp_busy_ff    <= rsp_busy_in;
   end

   // symbol ring, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[write_pos_ff] <= wr_sym;
      end
      rd_data_ff <= ring_mem[ptr_ff];
   end

   `NECTX_ASSERT_IMP(a_carrier_mark, carrier_ff, mark_left_ff != 8'd0)
   `NECTX_ASSERT_IMP(a_scan_in_run, state_ff == ST_SCAN_CHK, ptr_ff != write_pos_ff)
   `NECTX_ASSERT_IMP(a_enq_bound, state_ff == ST_ENQ, enq_cnt_ff <= enq_last)
   `NECTX_ASSERT_NEXT(a_done_emits, state_ff == ST_DONE && out_free, state_ff == ST_IDLE && rsp_valid_ff)

endmodule
